@@ sv/auto_range_contrast_stretch_top_defines.svh @@
// ----------------------------------------------------------------------------
// auto range contrast stretch assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef AUTO_RANGE_CONTRAST_STRETCH_TOP_DEFINES_SVH
`define AUTO_RANGE_CONTRAST_STRETCH_TOP_DEFINES_SVH

// property checked outside reset
`define ARCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define ARCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/arcs_pkg.sv @@
// ----------------------------------------------------------------------------
// arcs_pkg
// types and constants shared by the contrast stretch block
// ----------------------------------------------------------------------------
package arcs_pkg;

   localparam int PixW      = 8;
   localparam int CsrIdxW   = 8;
   localparam int ProdW     = 2 * PixW;
   localparam int DivSteps  = ProdW / 2;
   localparam int DivCntW   = $clog2(DivSteps);

   localparam logic [PixW-1:0] PixMax = '1;
   localparam logic [PixW-1:0] PixMin = '0;

   localparam logic [CsrIdxW-1:0] RegTargetLow  = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] RegTargetHigh = CsrIdxW'(1);

   localparam logic FuncMeasure = 1'b0;
   localparam logic FuncStretch = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic measure;
      logic capture;
      logic mul;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

@@ sv/arcs_ifs.sv @@
// ----------------------------------------------------------------------------
// arcs channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface arcs_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] pixel;
   logic       first;

   modport source (output valid, output func, output pixel, output first, input ready);
   modport sink   (input valid, input func, input pixel, input first, output ready);
endinterface

interface arcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;

   modport source (output valid, output pixel_out, input ready);
   modport sink   (input valid, input pixel_out, output ready);
endinterface

interface arcs_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/arcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// arcs_ctrl
// sequencer for accept, product, divide and output load
// ----------------------------------------------------------------------------
module arcs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   output logic             req_ready,
   output arcs_pkg::cmd_type cmd,
   input  arcs_pkg::sts_type sts
);
   import arcs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_func == FuncStretch)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.measure = req_valid && (req_func == FuncMeasure);
            cmd.capture = req_valid && (req_func == FuncStretch);
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_DONE: begin
            cmd.out_load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ sv/arcs_dp.sv @@
// ----------------------------------------------------------------------------
// arcs_dp
// range tracking, target registers, multiplier, radix-4 divider, output stage
// ----------------------------------------------------------------------------
module arcs_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  arcs_pkg::cmd_type             cmd,
   output arcs_pkg::sts_type             sts,
   input  logic [arcs_pkg::PixW-1:0]     req_pixel,
   input  logic                          req_first,
   input  logic                          csr_we,
   input  logic [arcs_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [arcs_pkg::PixW-1:0]     csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [arcs_pkg::PixW-1:0]     rsp_pixel_out
);
   import arcs_pkg::*;

   logic [PixW-1:0]    low_ff, low_in, high_ff, high_in;
   logic [PixW-1:0]    tlow_ff, tlow_in, thigh_ff, thigh_in;
   logic [PixW-1:0]    pix_ff, pix_in;
   logic [ProdW-1:0]   dvd_ff, dvd_in;
   logic [PixW-1:0]    rem_ff, rem_in;
   logic [PixW-1:0]    den_ff, den_in;
   logic               neg_ff, neg_in;
   logic               bypass_ff, bypass_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [PixW-1:0]    out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic [PixW-1:0]    base_low, base_high;
   logic [PixW:0]      diff;
   logic [PixW-1:0]    diff_mag;
   logic [PixW-1:0]    span;
   logic [PixW:0]      r1, r2;
   logic               q1, q2;
   logic [PixW-1:0]    r1_left;
   logic [PixW-1:0]    quo;
   logic [PixW-1:0]    quo_signed;

   // restart tracking before the pixel is counted
   assign base_low  = req_first ? PixMax : low_ff;
   assign base_high = req_first ? PixMin : high_ff;

   assign diff     = {1'b0, pix_ff} - {1'b0, low_ff};
   assign diff_mag = diff[PixW] ? PixW'(low_ff - pix_ff) : diff[PixW-1:0];
   assign span     = thigh_ff - tlow_ff;

   // two restoring steps per cycle
   assign r1      = {rem_ff, dvd_ff[ProdW-1]};
   assign q1      = (r1 >= {1'b0, den_ff});
   assign r1_left = q1 ? PixW'(r1 - {1'b0, den_ff}) : r1[PixW-1:0];
   assign r2      = {r1_left, dvd_ff[ProdW-2]};
   assign q2      = (r2 >= {1'b0, den_ff});

   assign quo        = dvd_ff[PixW-1:0];
   assign quo_signed = neg_ff ? PixW'(~quo + PixW'(1)) : quo;

   always_comb begin
      low_in       = low_ff;
      high_in      = high_ff;
      tlow_in      = tlow_ff;
      thigh_in     = thigh_ff;
      pix_in       = pix_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      bypass_in    = bypass_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      if (csr_we && (csr_index == RegTargetLow)) begin
         tlow_in = csr_data;
      end
      if (csr_we && (csr_index == RegTargetHigh)) begin
         thigh_in = csr_data;
      end

      if (cmd.measure) begin
         low_in  = (req_pixel < base_low)  ? req_pixel : base_low;
         high_in = (req_pixel > base_high) ? req_pixel : base_high;
      end
      if (cmd.capture) begin
         pix_in = req_pixel;
      end
      if (cmd.mul) begin
         dvd_in    = ProdW'(diff_mag) * ProdW'(span);
         neg_in    = diff[PixW];
         den_in    = high_ff - low_ff;
         bypass_in = (low_ff >= high_ff) || (tlow_ff > thigh_ff);
         rem_in    = '0;
         cnt_in    = '0;
      end
      if (cmd.div_step) begin
         dvd_in = {dvd_ff[ProdW-3:0], q1, q2};
         rem_in = q2 ? PixW'(r2 - {1'b0, den_ff}) : r2[PixW-1:0];
         cnt_in = cnt_ff + DivCntW'(1);
      end

      if (rsp_valid && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_in       = bypass_ff ? pix_ff : PixW'(quo_signed + tlow_ff);
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= PixMax;
         high_ff      <= PixMin;
         tlow_ff      <= PixMin;
         thigh_ff     <= PixMax;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         tlow_ff      <= tlow_in;
         thigh_ff     <= thigh_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff    <= pix_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      bypass_ff <= bypass_in;
      out_ff    <= out_in;
   end

   assign sts.div_last = (cnt_ff == DivCntW'(DivSteps - 1));
   assign sts.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_ff;

endmodule

@@ sv/auto_range_contrast_stretch_top.sv @@
// ----------------------------------------------------------------------------
// auto_range_contrast_stretch_top
// two-pass auto-range linear contrast stretch of 8-bit pixels
// ----------------------------------------------------------------------------
// A measure request (func 0) updates the running minimum and maximum in the
// cycle it is accepted and gives no response; the next request is taken in the
// following cycle. A stretch request (func 1) runs in order through accept, the
// 8x8 product of pixel offset and target span, the radix-4 restoring divide by
// the measured range (two quotient bits a cycle), and the add of the target low
// level into the output register. A waiting response does not stop measure
// requests; a stretch request holds in its last cycle until the output register
// is free. Register writes are taken every cycle.
module auto_range_contrast_stretch_top (
   input  logic         clock,
   input  logic         reset,
   arcs_req_if.sink     req_ch,
   arcs_rsp_if.source   rsp_ch,
   arcs_csr_if.sink     csr_ch
);
   import arcs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ch.ready = 1'b1;

   arcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   arcs_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_pixel     (req_ch.pixel),
      .req_first     (req_ch.first),
      .csr_we        (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_pixel_out (rsp_ch.pixel_out)
   );

endmodule

@@ sv/arcs_checker.sv @@
// ----------------------------------------------------------------------------
// arcs_checker
// port-level checks on the contrast stretch block
// ----------------------------------------------------------------------------
`include "auto_range_contrast_stretch_top_defines.svh"

module arcs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_func,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pixel_out
);
   import arcs_pkg::*;

   // response held until taken
   `ARCS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `ARCS_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_pixel_out), "response changed while stalled")
   // stretch work keeps the request side closed
   `ARCS_ASSERT(a_stretch_busy, clock, reset, req_valid && req_ready && (req_func == FuncStretch) |=> !req_ready, "request taken during stretch")
   // measure requests never stall the request side
   `ARCS_ASSERT(a_measure_open, clock, reset, req_valid && req_ready && (req_func == FuncMeasure) |=> req_ready, "measure request stalled the block")
   `ARCS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response pending after reset")

endmodule

bind auto_range_contrast_stretch_top arcs_checker u_arcs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_func      (req_ch.func),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_pixel_out (rsp_ch.pixel_out)
);

@@ tb/auto_range_contrast_stretch_top_tb.sv @@
// ----------------------------------------------------------------------------
// auto_range_contrast_stretch_top_tb
// drives measure and stretch pixel requests through the contrast stretch block
// and checks every stretched pixel against a cycle-free predictor of the
// min/max tracking and the signed linear mapping, under several target ranges
// and idle patterns, including a long response hold-off
// ----------------------------------------------------------------------------
module auto_range_contrast_stretch_top_tb;
   import arcs_pkg::*;

   localparam int StretchLatency = 12;
   localparam int HoldLen        = 300;
   localparam int QuietLimit     = 4000;
   localparam int RunItems       = 95;
   localparam int MaxReports     = 10;

   localparam logic [CsrIdxW-1:0] RegSpare = CsrIdxW'(2);
   localparam logic [CsrIdxW-1:0] RegTop   = '1;

   typedef struct {
      logic            func;
      logic [PixW-1:0] pixel;
      logic            first;
   } pixel_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   arcs_req_if req_ch ();
   arcs_rsp_if rsp_ch ();
   arcs_csr_if csr_ch ();

   auto_range_contrast_stretch_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pixel_req_type   pending_pixels[$];
   logic [PixW-1:0] stretched_due[$];

   // predictor state
   logic [PixW-1:0] span_lo = PixMin;
   logic [PixW-1:0] span_hi = PixMax;
   logic [PixW-1:0] run_min = PixMax;
   logic [PixW-1:0] run_max = PixMin;

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_ask      = 0;
   int   hold_seen     = 0;
   int   hold_left     = 0;
   int   quiet_cycles  = 0;
   int   bad_count     = 0;
   logic req_acc       = 1'b0;

   function automatic logic [PixW-1:0] stretch_level(logic [PixW-1:0] pixel);
      int num;
      int den;
      int val;
      if (run_min >= run_max || span_lo > span_hi) begin
         return pixel;
      end
      num = (int'(pixel) - int'(run_min)) * (int'(span_hi) - int'(span_lo));
      den = int'(run_max) - int'(run_min);
      // int division truncates toward zero, wrap modulo 256
      val = num / den + int'(span_lo);
      return val[PixW-1:0];
   endfunction

   // request driver
   always @(negedge clock) begin
      if (req_acc) begin
         void'(pending_pixels.pop_front());
      end
      if (req_ch.valid && !req_acc) begin
         // hold the request until it is taken
      end else if (!reset && pending_pixels.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
         req_ch.valid <= 1'b1;
         req_ch.func  <= pending_pixels[0].func;
         req_ch.pixel <= pending_pixels[0].pixel;
         req_ch.first <= pending_pixels[0].first;
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // response ready, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_seen != hold_ask) begin
         hold_seen    <= hold_ask;
         hold_left    <= HoldLen;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      logic [PixW-1:0] want;
      logic            req_fire;
      logic            rsp_fire;
      logic            csr_fire;
      if (reset) begin
         req_acc      <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_fire = req_ch.valid && req_ch.ready;
         rsp_fire = rsp_ch.valid && rsp_ch.ready;
         csr_fire = csr_ch.valid && csr_ch.ready;
         req_acc <= req_fire;
         if (csr_fire) begin
            if (csr_ch.index == RegTargetLow) begin
               span_lo = csr_ch.data;
            end else if (csr_ch.index == RegTargetHigh) begin
               span_hi = csr_ch.data;
            end
         end
         if (req_fire) begin
            if (req_ch.func == FuncMeasure) begin
               if (req_ch.first) begin
                  run_min = PixMax;
                  run_max = PixMin;
               end
               if (req_ch.pixel < run_min) begin
                  run_min = req_ch.pixel;
               end
               if (req_ch.pixel > run_max) begin
                  run_max = req_ch.pixel;
               end
            end else begin
               stretched_due.push_back(stretch_level(req_ch.pixel));
            end
         end
         if (rsp_fire) begin
            if (stretched_due.size() == 0) begin
               if (bad_count < MaxReports) begin
                  $display("unexpected response: pixel_out %0d", rsp_ch.pixel_out);
               end
               bad_count = bad_count + 1;
            end else begin
               want = stretched_due.pop_front();
               if (rsp_ch.pixel_out !== want) begin
                  if (bad_count < MaxReports) begin
                     $display("pixel_out mismatch: expected %0d, got %0d",
                              want, rsp_ch.pixel_out);
                  end
                  bad_count = bad_count + 1;
               end
            end
         end
         quiet_cycles <= (req_fire || rsp_fire || csr_fire) ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QuietLimit);
      $display("Some tests failed");
      $finish;
   end

   task automatic add_pixel(logic func, logic [PixW-1:0] pixel, logic first);
      pixel_req_type item;
      item.func  = func;
      item.pixel = pixel;
      item.first = first;
      pending_pixels.push_back(item);
   endtask

   task automatic csr_write(logic [CsrIdxW-1:0] index, logic [PixW-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_pixels.size() != 0);
      do @(negedge clock); while (stretched_due.size() != 0);
      repeat (StretchLatency) @(posedge clock);
   endtask

   // mostly whole images: a measure pass then a stretch pass, plus loose noise
   task automatic add_images(int count);
      logic [PixW-1:0] img[16];
      int added;
      int n;
      int m;
      int a;
      int b;
      added = 0;
      while (added < count) begin
         if ($urandom_range(99) < 80) begin
            n = $urandom_range(1, 12);
            if ($urandom_range(9) == 0) begin
               a = 0;
               b = 255;
            end else begin
               a = $urandom_range(0, 255);
               b = $urandom_range(a, 255);
            end
            for (int i = 0; i < n; i++) begin
               img[i] = PixW'($urandom_range(a, b));
               add_pixel(FuncMeasure, img[i], i == 0);
            end
            m = $urandom_range(1, n + 2);
            for (int i = 0; i < m; i++) begin
               if ($urandom_range(99) < 85) begin
                  add_pixel(FuncStretch, img[$urandom_range(0, n - 1)],
                            1'($urandom_range(1)));
               end else begin
                  add_pixel(FuncStretch, PixW'($urandom_range(0, 255)),
                            1'($urandom_range(1)));
               end
            end
            added = added + n + m;
         end else begin
            add_pixel(1'($urandom_range(1)), PixW'($urandom_range(0, 255)),
                      1'($urandom_range(1)));
            added = added + 1;
         end
      end
   endtask

   initial begin
      logic [PixW-1:0] lo_tab[6];
      logic [PixW-1:0] hi_tab[6];
      lo_tab = '{8'd0, 8'd200, 8'd37, 8'd255, 8'd0, PixW'($urandom_range(0, 255))};
      hi_tab = '{8'd255, 8'd10, 8'd37, 8'd255, 8'd0, PixW'($urandom_range(0, 255))};

      req_ch.valid = 1'b0;
      req_ch.func  = FuncMeasure;
      req_ch.pixel = '0;
      req_ch.first = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data  = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // writes to unmapped indexes must leave the targets alone
      csr_write(RegSpare, 8'hAA);
      csr_write(RegTop, 8'h55);
      csr_write(RegTargetLow, 8'd0);
      csr_write(RegTargetHigh, 8'd255);

      // nothing measured yet: pass-through
      add_pixel(FuncStretch, 8'd0, 1'b0);
      add_pixel(FuncStretch, 8'd255, 1'b0);
      // single pixel range is degenerate
      add_pixel(FuncMeasure, 8'd128, 1'b1);
      add_pixel(FuncStretch, 8'd128, 1'b0);
      add_pixel(FuncStretch, 8'd7, 1'b0);
      // full range
      add_pixel(FuncMeasure, 8'd0, 1'b1);
      add_pixel(FuncMeasure, 8'd255, 1'b0);
      add_pixel(FuncStretch, 8'd0, 1'b0);
      add_pixel(FuncStretch, 8'd255, 1'b0);
      add_pixel(FuncStretch, 8'd127, 1'b1);
      // narrow range, pixels outside it go negative or wrap
      add_pixel(FuncMeasure, 8'd50, 1'b1);
      add_pixel(FuncMeasure, 8'd60, 1'b0);
      add_pixel(FuncMeasure, 8'd55, 1'b0);
      add_pixel(FuncStretch, 8'd0, 1'b0);
      add_pixel(FuncStretch, 8'd255, 1'b0);
      add_pixel(FuncStretch, 8'd55, 1'b0);
      // extend without restart
      add_pixel(FuncMeasure, 8'd10, 1'b0);
      add_pixel(FuncStretch, 8'd10, 1'b0);
      add_pixel(FuncStretch, 8'd200, 1'b0);
      // restart onto the top level only
      add_pixel(FuncMeasure, 8'd255, 1'b1);
      add_pixel(FuncStretch, 8'd3, 1'b0);

      for (int r = 0; r < 6; r++) begin
         wait_drained();
         csr_write(RegTargetLow, lo_tab[r]);
         csr_write(RegTargetHigh, hi_tab[r]);
         case (r % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 50;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 50;
            end
            default: begin
               send_idle_pct = 14;
               rsp_stall_pct = 14;
            end
         endcase
         add_images(RunItems);

         if (r == 0) begin
            // back pressure: responses held off while stretch requests keep coming
            wait_drained();
            add_pixel(FuncMeasure, 8'd20, 1'b1);
            add_pixel(FuncMeasure, 8'd220, 1'b0);
            hold_ask = hold_ask + 1;
            for (int i = 0; i < 30; i++) begin
               add_pixel(FuncStretch, PixW'($urandom_range(0, 255)), 1'b0);
            end
         end
      end

      wait_drained();
      repeat (30) @(posedge clock);
      if (bad_count == 0 && stretched_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/arcs_pkg.sv
sv/arcs_ifs.sv
sv/arcs_ctrl.sv
sv/arcs_dp.sv
sv/auto_range_contrast_stretch_top.sv
sv/arcs_checker.sv
tb/auto_range_contrast_stretch_top_tb.sv
